// ----- rtl/assert_macros.svh -----
// assertion macros used by the sequencer back end
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, checked out of reset
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle implication failed");

// next-cycle implication, checked out of reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle implication failed");

`endif

// ----- rtl/jtsq_pkg.sv -----
// types, codes and the tap transition table of the jtag sequencer
package jtsq_pkg;

    // function codes on the input side
    localparam logic [2:0] FUNC_SHIFT_DR = 3'd0;
    localparam logic [2:0] FUNC_SHIFT_IR = 3'd1;
    localparam logic [2:0] FUNC_GO_IDLE  = 3'd2;
    localparam logic [2:0] FUNC_RUN      = 3'd3;
    localparam logic [2:0] FUNC_SAMPLE   = 3'd4;

    // tap states used by name
    localparam logic [3:0] TAP_RESET = 4'd0;
    localparam logic [3:0] TAP_IDLE  = 4'd1;

    // tms-high ticks before the final tms-low tick of go idle
    localparam logic [6:0] GO_IDLE_HIGH_TICKS = 7'd6;

    // queue between front and back, power of two
    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_PTR_W = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_NOT_IDLE = 2'd1,
        ST_UNEXP    = 2'd2,
        ST_BAD_LEN  = 2'd3
    } status_t;

    // item class decided in the front
    typedef enum logic [2:0] {
        CLS_DR      = 3'd0,
        CLS_IR      = 3'd1,
        CLS_GO_IDLE = 3'd2,
        CLS_RUN     = 3'd3,
        CLS_SAMPLE  = 3'd4,
        CLS_BAD     = 3'd5
    } cls_t;

    // running command
    typedef enum logic [4:0] {
        ACT_NONE    = 5'b00001,
        ACT_DR      = 5'b00010,
        ACT_IR      = 5'b00100,
        ACT_GO_IDLE = 5'b01000,
        ACT_RUN     = 5'b10000
    } act_t;

    // step within a dr or ir shift
    typedef enum logic [6:0] {
        PH_SEL1  = 7'b0000001,
        PH_SEL2  = 7'b0000010,
        PH_CAP   = 7'b0000100,
        PH_ENTER = 7'b0001000,
        PH_SHIFT = 7'b0010000,
        PH_UPD   = 7'b0100000,
        PH_IDLE  = 7'b1000000
    } phase_t;

    // classified item held in the queue
    typedef struct packed {
        cls_t        cls;
        logic        len_bad;
        logic        count_zero;
        logic [63:0] shift_data;
        logic [15:0] count;
        logic        tdo_level;
    } entry_t;

    // result item
    typedef struct packed {
        logic        drive_tick;
        logic        tms_out;
        logic        tdi_out;
        logic [3:0]  tap_position;
        logic        done_res;
        status_t     status;
        logic [63:0] captured_data;
    } result_t;

    // next tap state for a given tms level
    function automatic logic [3:0] tap_step(input logic [3:0] st, input logic tms);
        logic [3:0] nxt;
        unique case (st)
            4'd0:  nxt = tms ? 4'd0  : 4'd1;
            4'd1:  nxt = tms ? 4'd2  : 4'd1;
            4'd2:  nxt = tms ? 4'd9  : 4'd3;
            4'd3:  nxt = tms ? 4'd5  : 4'd4;
            4'd4:  nxt = tms ? 4'd5  : 4'd4;
            4'd5:  nxt = tms ? 4'd8  : 4'd6;
            4'd6:  nxt = tms ? 4'd7  : 4'd6;
            4'd7:  nxt = tms ? 4'd8  : 4'd4;
            4'd8:  nxt = tms ? 4'd2  : 4'd1;
            4'd9:  nxt = tms ? 4'd0  : 4'd10;
            4'd10: nxt = tms ? 4'd12 : 4'd11;
            4'd11: nxt = tms ? 4'd12 : 4'd11;
            4'd12: nxt = tms ? 4'd15 : 4'd13;
            4'd13: nxt = tms ? 4'd14 : 4'd13;
            4'd14: nxt = tms ? 4'd15 : 4'd11;
            4'd15: nxt = tms ? 4'd2  : 4'd1;
            default: nxt = TAP_RESET;
        endcase
        return nxt;
    endfunction

endpackage

// ----- rtl/jtsq_front.sv -----
// front end: takes input items and classifies them for the queue
module jtsq_front #(
    parameter int MAX_SHIFT_BITS = 64
) (
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [87:0]       s_tdata,   // shift_data[63:0], count[79:64], tdo_level[80]
    input  logic [2:0]        s_tuser,   // func[2:0]
    input  logic              q_full,
    output logic              q_push,
    output jtsq_pkg::entry_t  q_entry
);

    logic [15:0] count;

    assign count    = s_tdata[79:64];
    assign s_tready = !q_full;
    assign q_push   = s_tvalid && !q_full;

    // decode function code and precompute length checks
    always_comb begin
        q_entry            = '0;
        q_entry.shift_data = s_tdata[63:0];
        q_entry.count      = count;
        q_entry.tdo_level  = s_tdata[80];
        q_entry.count_zero = (count == 16'd0);
        q_entry.len_bad    = (count == 16'd0) || (count > 16'(MAX_SHIFT_BITS));
        unique case (s_tuser)
            jtsq_pkg::FUNC_SHIFT_DR: q_entry.cls = jtsq_pkg::CLS_DR;
            jtsq_pkg::FUNC_SHIFT_IR: q_entry.cls = jtsq_pkg::CLS_IR;
            jtsq_pkg::FUNC_GO_IDLE:  q_entry.cls = jtsq_pkg::CLS_GO_IDLE;
            jtsq_pkg::FUNC_RUN:      q_entry.cls = jtsq_pkg::CLS_RUN;
            jtsq_pkg::FUNC_SAMPLE:   q_entry.cls = jtsq_pkg::CLS_SAMPLE;
            default:                 q_entry.cls = jtsq_pkg::CLS_BAD;
        endcase
    end

endmodule

// ----- rtl/jtsq_queue.sv -----
// short fifo of classified items between front and back
module jtsq_queue (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              push,
    input  jtsq_pkg::entry_t  push_entry,
    input  logic              pop,
    output logic              not_empty,
    output logic              full,
    output jtsq_pkg::entry_t  head
);

    localparam int PTR_W = jtsq_pkg::QUEUE_PTR_W;
    localparam int CNT_W = jtsq_pkg::QUEUE_CNT_W;

    jtsq_pkg::entry_t slot_reg [jtsq_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             do_push, do_pop;

    assign not_empty = (cnt_reg != '0);
    assign full      = (cnt_reg == CNT_W'(jtsq_pkg::QUEUE_DEPTH));
    assign head      = slot_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;

    // pointer and fill count
    always_comb begin
        wr_ptr_next = do_push ? wr_ptr_reg + PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + PTR_W'(1) : rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (do_push && !do_pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (do_pop && !do_push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    // slot storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ----- rtl/jtsq_back.sv -----
// back end: tap state tracking, shift sequencing and result register
`include "assert_macros.svh"

module jtsq_back (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              q_valid,
    input  jtsq_pkg::entry_t  q_entry,
    output logic              q_pop,
    output logic              m_valid,
    input  logic              m_ready,
    output jtsq_pkg::result_t m_res
);

    logic                fire;
    jtsq_pkg::result_t   res_reg, res_next;
    logic                out_valid_reg;

    logic [3:0]          tap_reg, tap_next;
    jtsq_pkg::act_t      act_reg, act_next;
    jtsq_pkg::phase_t    phase_reg, phase_next;
    logic [6:0]          bp_reg, bp_next;
    logic [6:0]          len_reg, len_next;
    logic [63:0]         obits_reg, obits_next;
    logic [63:0]         ibits_reg, ibits_next;
    logic [15:0]         ticks_reg, ticks_next;

    logic                tick_req, tick_tms, tick_tdi;
    logic [6:0]          bp_inc, bp_inc2;
    logic [15:0]         ticks_dec;

    assign fire    = q_valid && (!out_valid_reg || m_ready);
    assign q_pop   = fire;
    assign m_valid = out_valid_reg;
    assign m_res   = res_reg;

    assign bp_inc    = bp_reg + 7'd1;
    assign bp_inc2   = bp_reg + 7'd2;
    assign ticks_dec = (ticks_reg != 16'd0) ? ticks_reg - 16'd1 : ticks_reg;

    // one step of the sequencer per item
    always_comb begin
        res_next              = '0;
        res_next.tap_position = tap_reg;
        res_next.status       = jtsq_pkg::ST_OK;
        tick_req   = 1'b0;
        tick_tms   = 1'b0;
        tick_tdi   = 1'b0;
        tap_next   = tap_reg;
        act_next   = act_reg;
        phase_next = phase_reg;
        bp_next    = bp_reg;
        len_next   = len_reg;
        obits_next = obits_reg;
        ibits_next = ibits_reg;
        ticks_next = ticks_reg;

        if (q_entry.cls == jtsq_pkg::CLS_BAD) begin
            res_next.done_res = 1'b1;
            res_next.status   = jtsq_pkg::ST_UNEXP;
        end else if (act_reg == jtsq_pkg::ACT_NONE) begin
            // no command running: start one, or finish the item at once with a done result
            priority if (q_entry.cls == jtsq_pkg::CLS_SAMPLE) begin
                res_next.done_res = 1'b1;
                res_next.status   = jtsq_pkg::ST_UNEXP;
            end else if (q_entry.cls == jtsq_pkg::CLS_GO_IDLE) begin
                act_next = jtsq_pkg::ACT_GO_IDLE;
                bp_next  = 7'd0;
                tick_req = 1'b1;
                tick_tms = 1'b1;
                tick_tdi = 1'b1;
            end else if (tap_reg != jtsq_pkg::TAP_IDLE) begin
                res_next.done_res = 1'b1;
                res_next.status   = jtsq_pkg::ST_NOT_IDLE;
            end else if (q_entry.cls == jtsq_pkg::CLS_RUN) begin
                if (q_entry.count_zero) begin
                    res_next.done_res = 1'b1;
                end else begin
                    act_next   = jtsq_pkg::ACT_RUN;
                    ticks_next = q_entry.count;
                    tick_req   = 1'b1;
                    tick_tdi   = 1'b1;
                end
            end else if (q_entry.len_bad) begin
                res_next.done_res = 1'b1;
                res_next.status   = jtsq_pkg::ST_BAD_LEN;
            end else begin
                act_next   = (q_entry.cls == jtsq_pkg::CLS_IR) ? jtsq_pkg::ACT_IR
                                                               : jtsq_pkg::ACT_DR;
                phase_next = jtsq_pkg::PH_SEL1;
                bp_next    = 7'd0;
                len_next   = q_entry.count[6:0];
                obits_next = q_entry.shift_data;
                ibits_next = '0;
                tick_req   = 1'b1;
                tick_tms   = 1'b1;
                tick_tdi   = 1'b1;
            end
        end else if (q_entry.cls != jtsq_pkg::CLS_SAMPLE) begin
            // command while a sample is awaited
            res_next.done_res = 1'b1;
            res_next.status   = jtsq_pkg::ST_UNEXP;
        end else begin
            // sample for the running command
            tick_req = 1'b1;
            tick_tdi = 1'b1;
            unique case (act_reg)
                jtsq_pkg::ACT_GO_IDLE: begin
                    if (bp_reg >= jtsq_pkg::GO_IDLE_HIGH_TICKS) begin
                        tick_req = 1'b0;
                    end else begin
                        bp_next  = bp_inc;
                        tick_tms = (bp_inc < jtsq_pkg::GO_IDLE_HIGH_TICKS);
                    end
                end
                jtsq_pkg::ACT_RUN: begin
                    ticks_next = ticks_dec;
                    if (ticks_dec == 16'd0) begin
                        tick_req = 1'b0;
                    end
                end
                jtsq_pkg::ACT_DR, jtsq_pkg::ACT_IR: begin
                    unique case (phase_reg)
                        jtsq_pkg::PH_SEL1: begin
                            if (act_reg == jtsq_pkg::ACT_IR) begin
                                phase_next = jtsq_pkg::PH_SEL2;
                                tick_tms   = 1'b1;
                            end else begin
                                phase_next = jtsq_pkg::PH_CAP;
                            end
                        end
                        jtsq_pkg::PH_SEL2:  phase_next = jtsq_pkg::PH_CAP;
                        jtsq_pkg::PH_CAP:   phase_next = jtsq_pkg::PH_ENTER;
                        jtsq_pkg::PH_ENTER: begin
                            phase_next = jtsq_pkg::PH_SHIFT;
                            tick_tms   = (bp_inc >= len_reg);
                            tick_tdi   = obits_reg[bp_reg[5:0]];
                        end
                        jtsq_pkg::PH_SHIFT: begin
                            ibits_next[bp_reg[5:0]] = ibits_reg[bp_reg[5:0]]
                                                      | q_entry.tdo_level;
                            bp_next = bp_inc;
                            if (bp_inc >= len_reg) begin
                                phase_next = jtsq_pkg::PH_UPD;
                                tick_tms   = 1'b1;
                            end else begin
                                tick_tms = (bp_inc2 >= len_reg);
                                tick_tdi = obits_reg[bp_inc[5:0]];
                            end
                        end
                        jtsq_pkg::PH_UPD:   phase_next = jtsq_pkg::PH_IDLE;
                        jtsq_pkg::PH_IDLE: begin
                            tick_req               = 1'b0;
                            res_next.captured_data = ibits_reg;
                        end
                        default: tick_req = 1'b0;
                    endcase
                end
                default: tick_req = 1'b0;
            endcase

            // command finished: done result and clean state
            if (!tick_req) begin
                res_next.done_res = 1'b1;
                act_next   = jtsq_pkg::ACT_NONE;
                phase_next = jtsq_pkg::PH_SEL1;
                bp_next    = 7'd0;
                ticks_next = 16'd0;
            end
        end

        // tick result moves the tap
        if (tick_req) begin
            tap_next              = jtsq_pkg::tap_step(tap_reg, tick_tms);
            res_next.drive_tick   = 1'b1;
            res_next.tms_out      = tick_tms;
            res_next.tdi_out      = tick_tdi;
            res_next.tap_position = tap_next;
        end
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
            tap_reg       <= jtsq_pkg::TAP_RESET;
            act_reg       <= jtsq_pkg::ACT_NONE;
            phase_reg     <= jtsq_pkg::PH_SEL1;
            bp_reg        <= 7'd0;
            ticks_reg     <= 16'd0;
        end else begin
            if (fire) begin
                out_valid_reg <= 1'b1;
                tap_reg       <= tap_next;
                act_reg       <= act_next;
                phase_reg     <= phase_next;
                bp_reg        <= bp_next;
                ticks_reg     <= ticks_next;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (fire) begin
            res_reg   <= res_next;
            len_reg   <= len_next;
            obits_reg <= obits_next;
            ibits_reg <= ibits_next;
        end
    end

    // no command running means a clean shift position
    `ASSERT_IMPL(a_none_clean, aclk, aresetn, act_reg == jtsq_pkg::ACT_NONE, phase_reg == jtsq_pkg::PH_SEL1 && bp_reg == 7'd0 && ticks_reg == 16'd0)
    // tap only moves on a tick result
    `ASSERT_NEXT(a_tap_hold, aclk, aresetn, fire && !res_next.drive_tick, tap_reg == $past(tap_reg))
    // shift position stays below the length while shifting
    `ASSERT_IMPL(a_shift_bound, aclk, aresetn, phase_reg == jtsq_pkg::PH_SHIFT && (act_reg == jtsq_pkg::ACT_DR || act_reg == jtsq_pkg::ACT_IR), bp_reg < len_reg)

endmodule

// ----- rtl/jtag_tap_master_sequencer.sv -----
// top level of the jtag tap host sequencer
//
//  channel | dir | handshake        | tdata                                | tuser / tlast
//  s_      | in  | s_tvalid/tready  | shift_data, count, tdo_level         | tuser = func
//  m_      | out | m_tvalid/tready  | tms, tdi, tap_position, status, data | tuser = drive_tick,
//          |     |                  |                                      | tlast = done_res
//
// one item per clock sustained while m_tready takes each result; every item gives exactly one result item.
// an accepted item is written into the queue, then executed by the back end into the
// output register once that register is empty or being taken, and offered from there.
// the back end retires one queued item per cycle whenever the output register
// is empty or being taken; the two-entry queue keeps s_tready high meanwhile.
// aresetn is synchronous and active low and puts the tap model in test logic reset.
module jtag_tap_master_sequencer #(
    parameter int MAX_SHIFT_BITS = 64
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [87:0] s_tdata,   // shift_data[63:0], count[79:64], tdo_level[80]
    input  logic [2:0]  s_tuser,   // func[2:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // tms_out[0], tdi_out[1], tap_position[5:2],
                                   // status[7:6], captured_data[71:8]
    output logic        m_tuser,   // drive_tick
    output logic        m_tlast    // done_res
);

    logic              q_push, q_full, q_not_empty, q_pop;
    jtsq_pkg::entry_t  push_entry, head_entry;
    jtsq_pkg::result_t res;

    jtsq_front #(
        .MAX_SHIFT_BITS(MAX_SHIFT_BITS)
    ) u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_entry  (push_entry)
    );

    jtsq_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_entry (push_entry),
        .pop        (q_pop),
        .not_empty  (q_not_empty),
        .full       (q_full),
        .head       (head_entry)
    );

    jtsq_back u_back (
        .aclk    (aclk),
        .aresetn (aresetn),
        .q_valid (q_not_empty),
        .q_entry (head_entry),
        .q_pop   (q_pop),
        .m_valid (m_tvalid),
        .m_ready (m_tready),
        .m_res   (res)
    );

    // pack result item onto the stream
    assign m_tdata = {res.captured_data, res.status, res.tap_position,
                      res.tdi_out, res.tms_out};
    assign m_tuser = res.drive_tick;
    assign m_tlast = res.done_res;

endmodule
